### sv/mwphc_pkg.sv
// Shared types, constants and state encodings of the median window pH calibration block.
package mwphc_pkg;

  // Window length of the sliding median.
  localparam int WINDOW = 16;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MID_HI = WINDOW / 2;
  localparam int MID_LO = ((WINDOW % 2) == 0) ? (WINDOW / 2 - 1) : (WINDOW / 2);

  // Field widths.
  localparam int RAW_W  = 24;
  localparam int TEMP_W = 15;
  localparam int MED_W  = 26;
  localparam int PH_W   = 16;
  localparam int CAL_W  = 23;
  localparam int GAIN_W = 16;
  localparam int ST_W   = 2;

  // Calibration products and wide arithmetic of the pH unit.
  localparam int PT_W   = CAL_W + GAIN_W;
  localparam int NUM_W  = 104;
  localparam int QW     = 42;
  localparam int TERM_W = 41;

  localparam logic [CAL_W-1:0]  ACID_RST    = CAL_W'(1025130);
  localparam logic [CAL_W-1:0]  NEUTRAL_RST = CAL_W'(755250);
  localparam logic [CAL_W-1:0]  BASE_RST    = CAL_W'(502500);
  localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(8192);

  typedef enum logic [1:0] {
    REG_ACID    = 2'd0,
    REG_NEUTRAL = 2'd1,
    REG_BASE    = 2'd2,
    REG_GAIN    = 2'd3
  } cfg_reg_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SCALE,
    T_INSERT,
    T_MEDIAN,
    T_PH,
    T_OUT
  } top_state_e;

  typedef enum logic [3:0] {
    P_IDLE,
    P_CAL,
    P_DIFF,
    P_PROD,
    P_MUL_NUM,
    P_MUL_DEN,
    P_CHK,
    P_DIV,
    P_ROUND,
    P_FIN
  } ph_state_e;

  // One element of the sorted chain: its value and the ring slot it came from.
  typedef struct packed {
    logic signed [MED_W-1:0] val;
    logic [SLOT_W-1:0]       slot;
  } entry_t;

endpackage

### sv/mwphc_cell.sv
// One cell of the sorted chain: holds one entry and does its part of a delete-and-insert.
module mwphc_cell import mwphc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [SLOT_W-1:0] init_slot_i,
  input  entry_t            ins_i,
  input  entry_t            right_i,
  input  logic              right_ok_i,
  input  logic              m_i,
  input  logic              g_i,
  input  entry_t            a_i,
  output entry_t            cur_o,
  output logic              m_o,
  output logic              g_o,
  output entry_t            a_o
);

  entry_t cur_q;
  entry_t cur_d;
  logic   vacant;

  // m: the entry being replaced sits here or further left, so this cell
  // takes its right neighbor after compaction. g: the compacted entry here
  // is larger than the new one.
  always_comb begin
    m_o    = m_i | (cur_q.slot == ins_i.slot);
    vacant = m_o & ~right_ok_i;
    a_o    = (m_o && right_ok_i) ? right_i : cur_q;
    g_o    = vacant | (a_o.val > ins_i.val);
    if (g_o) begin
      cur_d = g_i ? a_i : ins_i;
    end else begin
      cur_d = a_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.val  <= '0;
      cur_q.slot <= init_slot_i;
    end else if (en_i) begin
      cur_q <= cur_d;
    end
  end

  assign cur_o = cur_q;

endmodule

### sv/mwphc_chain.sv
// Row of sorted cells with the ring write slot; yields the two middle entries.
module mwphc_chain import mwphc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    ins_en_i,
  input  logic signed [MED_W-1:0] ins_val_i,
  output logic signed [MED_W-1:0] mid_lo_o,
  output logic signed [MED_W-1:0] mid_hi_o
);

  logic [SLOT_W-1:0] wslot_q;
  entry_t            ins;
  entry_t            cur [WINDOW];
  entry_t            a   [WINDOW];
  logic              m   [WINDOW];
  logic              g   [WINDOW];

  assign ins.val  = ins_val_i;
  assign ins.slot = wslot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q <= '0;
    end else if (ins_en_i) begin
      if (wslot_q == SLOT_W'(WINDOW - 1)) begin
        wslot_q <= '0;
      end else begin
        wslot_q <= wslot_q + SLOT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    entry_t right;
    logic   right_ok;
    logic   m_left;
    logic   g_left;
    entry_t a_left;

    if (i < WINDOW - 1) begin : g_mid
      assign right    = cur[i+1];
      assign right_ok = 1'b1;
    end else begin : g_last
      assign right    = cur[i];
      assign right_ok = 1'b0;
    end

    if (i > 0) begin : g_in
      assign m_left = m[i-1];
      assign g_left = g[i-1];
      assign a_left = a[i-1];
    end else begin : g_first
      assign m_left = 1'b0;
      assign g_left = 1'b0;
      assign a_left = cur[0];
    end

    mwphc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (ins_en_i),
      .init_slot_i(SLOT_W'(i)),
      .ins_i      (ins),
      .right_i    (right),
      .right_ok_i (right_ok),
      .m_i        (m_left),
      .g_i        (g_left),
      .a_i        (a_left),
      .cur_o      (cur[i]),
      .m_o        (m[i]),
      .g_o        (g[i]),
      .a_o        (a[i])
    );
  end

  assign mid_lo_o = cur[MID_LO].val;
  assign mid_hi_o = cur[MID_HI].val;

endmodule

### sv/mwphc_ph.sv
// Sequenced pH arithmetic: calibration products, serial multiplier and bit-serial divider.
module mwphc_ph import mwphc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [MED_W-1:0] med_i,
  input  logic signed [TEMP_W-1:0] tc_i,
  input  logic [CAL_W-1:0]        acid_i,
  input  logic [CAL_W-1:0]        neutral_i,
  input  logic [CAL_W-1:0]        base_i,
  input  logic [GAIN_W-1:0]       gain_i,
  output logic                    done_o,
  output logic signed [PH_W-1:0]  ph_o,
  output status_e                 status_o
);

  localparam logic [TERM_W-1:0] TERM_MAX = TERM_W'(1) << (TERM_W - 1);

  ph_state_e state_q, state_d;

  logic signed [MED_W-1:0]  med_q;
  logic signed [TEMP_W-1:0] tc_q;
  logic [PT_W-1:0]          na_q, aa_q, ba_q;
  logic signed [42:0]       qm_q;
  logic signed [PT_W:0]     da_q, db_q;
  logic signed [43:0]       qv_q;
  logic                     degen_q;
  logic signed [52:0]       p_q;
  logic [54:0]              dam_q;
  logic                     neg_q;
  logic [NUM_W-1:0]         acc_q, num_q, den_q, rem_q;
  logic [1:0]               dig_q;
  logic [QW-1:0]            qsh_q;
  logic [5:0]               bit_q;
  logic                     sat_q;
  logic [TERM_W-1:0]        term_q;

  logic signed [16:0]       tcoff;
  logic [PT_W:0]            da_mag, db_mag;
  logic [52:0]              p_mag;
  logic [43:0]              qv_mag;
  logic [55:0]              mul_a;
  logic [47:0]              mul_b;
  logic [15:0]              digit;
  logic [71:0]              pp;
  logic [NUM_W-1:0]         pp_sh, acc_nxt;
  logic [NUM_W:0]           rem_sh, rem_dif;
  logic                     div_ge, ovf, rnd;
  logic [QW:0]              q_rnd;
  logic signed [42:0]       sterm, ph_full;

  always_comb begin
    tcoff   = 17'(tc_q) + 17'sd27315;
    da_mag  = da_q[PT_W] ? (PT_W+1)'(-da_q) : (PT_W+1)'(da_q);
    db_mag  = db_q[PT_W] ? (PT_W+1)'(-db_q) : (PT_W+1)'(db_q);
    p_mag   = p_q[52] ? 53'(-p_q) : 53'(p_q);
    qv_mag  = qv_q[43] ? 44'(-qv_q) : 44'(qv_q);

    // Shared multiplier: one 16-bit digit of the second operand per cycle.
    if (state_q == P_MUL_NUM) begin
      mul_a = 56'(p_mag);
      mul_b = 48'(qv_mag);
    end else begin
      mul_a = 56'(dam_q);
      mul_b = 48'(db_mag);
    end
    case (dig_q)
      2'd0:    digit = mul_b[15:0];
      2'd1:    digit = mul_b[31:16];
      default: digit = mul_b[47:32];
    endcase
    pp = 72'(mul_a) * 72'(digit);
    case (dig_q)
      2'd0:    pp_sh = NUM_W'(pp);
      2'd1:    pp_sh = NUM_W'(pp) << 16;
      default: pp_sh = NUM_W'(pp) << 32;
    endcase
    acc_nxt = acc_q + pp_sh;

    ovf     = NUM_W'(num_q[NUM_W-1:QW]) >= den_q;
    rem_sh  = {rem_q, qsh_q[QW-1]};
    div_ge  = rem_sh >= {1'b0, den_q};
    rem_dif = rem_sh - {1'b0, den_q};
    rnd     = {rem_q, 1'b0} >= {1'b0, den_q};
    q_rnd   = (QW+1)'(qsh_q) + (QW+1)'(rnd);

    sterm   = neg_q ? -43'(term_q) : 43'(term_q);
    ph_full = 43'sd7000 + sterm;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      P_IDLE:    if (start_i) state_d = P_CAL;
      P_CAL:     state_d = P_DIFF;
      P_DIFF:    state_d = P_PROD;
      P_PROD:    state_d = degen_q ? P_FIN : P_MUL_NUM;
      P_MUL_NUM: if (dig_q == 2'd2) state_d = P_MUL_DEN;
      P_MUL_DEN: if (dig_q == 2'd2) state_d = P_CHK;
      P_CHK:     state_d = ovf ? P_ROUND : P_DIV;
      P_DIV:     if (bit_q == 6'd0) state_d = P_ROUND;
      P_ROUND:   state_d = P_FIN;
      P_FIN:     state_d = P_IDLE;
      default:   state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      P_IDLE: begin
        if (start_i) begin
          med_q <= med_i;
          tc_q  <= tc_i;
        end
      end
      P_CAL: begin
        na_q <= PT_W'(neutral_i) * PT_W'(gain_i);
        aa_q <= PT_W'(acid_i) * PT_W'(gain_i);
        ba_q <= PT_W'(base_i) * PT_W'(gain_i);
        qm_q <= 43'(med_q) * 43'(tcoff);
      end
      P_DIFF: begin
        da_q    <= $signed({1'b0, na_q}) - $signed({1'b0, aa_q});
        db_q    <= $signed({1'b0, na_q}) - $signed({1'b0, ba_q});
        degen_q <= (na_q == aa_q) || (na_q == ba_q);
        qv_q    <= 44'(qm_q) - 44'sd44722500000;
      end
      P_PROD: begin
        p_q   <= 53'(db_q) * 53'sd2990 - 53'(da_q) * 53'sd3000;
        dam_q <= 55'(da_mag) * 55'd29815;
        neg_q <= (qv_q[43] ^ (53'(db_q) * 53'sd2990 < 53'(da_q) * 53'sd3000))
                 ^ (da_q[PT_W] ^ db_q[PT_W]);
        acc_q <= '0;
        dig_q <= '0;
      end
      P_MUL_NUM: begin
        if (dig_q == 2'd2) begin
          num_q <= acc_nxt << 11;
          acc_q <= '0;
          dig_q <= '0;
        end else begin
          acc_q <= acc_nxt;
          dig_q <= dig_q + 2'd1;
        end
      end
      P_MUL_DEN: begin
        if (dig_q == 2'd2) begin
          den_q <= acc_nxt;
        end else begin
          acc_q <= acc_nxt;
          dig_q <= dig_q + 2'd1;
        end
      end
      P_CHK: begin
        rem_q <= NUM_W'(num_q[NUM_W-1:QW]);
        qsh_q <= num_q[QW-1:0];
        bit_q <= 6'(QW - 1);
        sat_q <= ovf;
      end
      P_DIV: begin
        rem_q <= div_ge ? rem_dif[NUM_W-1:0] : rem_sh[NUM_W-1:0];
        qsh_q <= {qsh_q[QW-2:0], div_ge};
        bit_q <= bit_q - 6'd1;
      end
      P_ROUND: begin
        if (sat_q || (q_rnd > (QW+1)'(TERM_MAX))) begin
          term_q <= TERM_MAX;
        end else begin
          term_q <= q_rnd[TERM_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    done_o = (state_q == P_FIN);
    if (degen_q) begin
      ph_o     = '0;
      status_o = ST_DEGEN;
    end else if (ph_full > 43'sd32767) begin
      ph_o     = 16'sh7FFF;
      status_o = ST_SAT;
    end else if (ph_full < -43'sd32768) begin
      ph_o     = -16'sh8000;
      status_o = ST_SAT;
    end else begin
      ph_o     = ph_full[PH_W-1:0];
      status_o = ST_OK;
    end
  end

endmodule

### sv/median_window_ph_calibration.sv
// Top level of the sliding-window median filter with pH calibration.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    raw_sample_uv_i, sample_ok_i, temp_centi_c_i
//   out      output     out_valid_o / out_stall_i  median_uv_o, ph_milli_o, status_o
//   config   input      psel/penable/pwrite/pready acid, neutral, base, divider gain at 0,4,8,12
//
// One transaction is worked on at a time, from acceptance to a result in the
// output register; the pH unit uses a one-bit-per-cycle divider. A degenerate
// calibration skips the multiplier and divider.
// Reset (rst_ni low, asynchronous) clears the sorted chain to zeros, the
// write slot and the calibration registers to their defaults.
// A stalled result waits in the output register while the next input
// transaction is already accepted and processed.
module median_window_ph_calibration import mwphc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [RAW_W-1:0]  raw_sample_uv_i,
  input  logic                     sample_ok_i,
  input  logic signed [TEMP_W-1:0] temp_centi_c_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [MED_W-1:0]  median_uv_o,
  output logic signed [PH_W-1:0]   ph_milli_o,
  output logic [ST_W-1:0]          status_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  top_state_e state_q, state_d;

  // Configuration registers.
  logic [CAL_W-1:0]  acid_q, neutral_q, base_q;
  logic [GAIN_W-1:0] gain_q;
  cfg_reg_e          reg_sel;
  logic              cfg_wr;

  // Captured input transaction and intermediate results.
  logic signed [RAW_W-1:0]  raw_q;
  logic                     ok_q;
  logic signed [TEMP_W-1:0] tc_q;
  logic signed [MED_W-1:0]  scaled_q;
  logic signed [MED_W-1:0]  med_q;
  logic signed [PH_W-1:0]   res_ph_q;
  status_e                  res_st_q;

  // Output register.
  logic                    out_valid_q;
  logic signed [MED_W-1:0] out_med_q;
  logic signed [PH_W-1:0]  out_ph_q;
  status_e                 out_st_q;

  logic signed [40:0]       scale_full;
  logic signed [40:0]       scale_sh;
  logic signed [MED_W-1:0]  mid_lo, mid_hi;
  logic signed [MED_W:0]    mid_sum;
  logic signed [MED_W-1:0]  median;
  logic                     ph_done;
  logic signed [PH_W-1:0]   ph_val;
  status_e                  ph_st;
  logic                     out_load;

  // ---------------------------------------------------------------------
  // Configuration port: writes complete in the access phase, no wait states.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acid_q    <= ACID_RST;
      neutral_q <= NEUTRAL_RST;
      base_q    <= BASE_RST;
      gain_q    <= GAIN_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ACID:    acid_q    <= pwdata[CAL_W-1:0];
        REG_NEUTRAL: neutral_q <= pwdata[CAL_W-1:0];
        REG_BASE:    base_q    <= pwdata[CAL_W-1:0];
        REG_GAIN:    gain_q    <= pwdata[GAIN_W-1:0];
        default:     gain_q    <= gain_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ACID:    prdata = 32'(acid_q);
      REG_NEUTRAL: prdata = 32'(neutral_q);
      REG_BASE:    prdata = 32'(base_q);
      REG_GAIN:    prdata = 32'(gain_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sample scaling: raw * gain / 4096, rounded half up, then saturated to
  // the 26-bit range of the store.
  // ---------------------------------------------------------------------
  always_comb begin
    scale_full = 41'(raw_q) * $signed({25'd0, gain_q}) + 41'sd2048;
    scale_sh   = scale_full >>> 12;
  end

  // ---------------------------------------------------------------------
  // Sorted chain. The cells keep the window in ascending order, each tagged
  // with its ring slot, so the oldest entry is dropped and the new one is
  // placed in the same cycle.
  // ---------------------------------------------------------------------
  mwphc_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ins_en_i (state_q == T_INSERT && ok_q),
    .ins_val_i(scaled_q),
    .mid_lo_o (mid_lo),
    .mid_hi_o (mid_hi)
  );

  // For an odd window both taps are the same cell, so the floor mean is exact.
  assign mid_sum = (MED_W+1)'(mid_lo) + (MED_W+1)'(mid_hi);
  assign median  = mid_sum[MED_W:1];

  mwphc_ph u_ph (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == T_MEDIAN),
    .med_i    (median),
    .tc_i     (tc_q),
    .acid_i   (acid_q),
    .neutral_i(neutral_q),
    .base_i   (base_q),
    .gain_i   (gain_q),
    .done_o   (ph_done),
    .ph_o     (ph_val),
    .status_o (ph_st)
  );

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != T_IDLE);
  assign out_load   = (state_q == T_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE:   if (in_valid_i) state_d = T_SCALE;
      T_SCALE:  state_d = T_INSERT;
      T_INSERT: state_d = T_MEDIAN;
      T_MEDIAN: state_d = T_PH;
      T_PH:     if (ph_done) state_d = T_OUT;
      T_OUT:    if (out_load) state_d = T_IDLE;
      default:  state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_IDLE && in_valid_i) begin
      raw_q <= raw_sample_uv_i;
      ok_q  <= sample_ok_i;
      tc_q  <= temp_centi_c_i;
    end
    if (state_q == T_SCALE) begin
      if (scale_sh > 41'sd33554431) begin
        scaled_q <= 26'sh1FFFFFF;
      end else if (scale_sh < -41'sd33554432) begin
        scaled_q <= -26'sh2000000;
      end else begin
        scaled_q <= scale_sh[MED_W-1:0];
      end
    end
    if (state_q == T_MEDIAN) begin
      med_q <= median;
    end
    if (state_q == T_PH && ph_done) begin
      res_ph_q <= ph_val;
      res_st_q <= ph_st;
    end
    if (out_load) begin
      out_med_q <= med_q;
      out_ph_q  <= res_ph_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_uv_o = out_med_q;
  assign ph_milli_o  = out_ph_q;
  assign status_o    = out_st_q;

endmodule

### sv/mwphc_checker.sv
// Port-level assertions for the median window pH calibration block, with its bind.
module mwphc_checker import mwphc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [MED_W-1:0]  median_uv_o,
  input logic signed [PH_W-1:0]   ph_milli_o,
  input logic [ST_W-1:0]          status_o
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_uv_o)
      && $stable(ph_milli_o) && $stable(status_o))
    else $error("stalled result changed");

  // The block works on one transaction at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while busy");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DEGEN |-> ph_milli_o == '0)
    else $error("degenerate calibration with nonzero pH");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SAT |->
      ph_milli_o == 16'sh7FFF || ph_milli_o == -16'sh8000)
    else $error("saturation flagged on unsaturated pH");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_DEGEN || status_o == ST_SAT)
    else $error("undefined status code");

endmodule

bind median_window_ph_calibration mwphc_checker u_mwphc_checker (.*);

### test/testbench.sv
// Self-checking testbench for the median window pH calibration block.
module testbench;
  import mwphc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [RAW_W-1:0] raw_sample_uv_i = '0;
  logic sample_ok_i = 1'b0;
  logic signed [TEMP_W-1:0] temp_centi_c_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [MED_W-1:0] median_uv_o;
  logic signed [PH_W-1:0] ph_milli_o;
  logic [ST_W-1:0] status_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  median_window_ph_calibration u_dut (.*);

  // The clock runs with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // One expected result: the filtered median, the pH and the status code.
  typedef struct {
    logic signed [MED_W-1:0] median;
    logic signed [PH_W-1:0] ph;
    status_e status;
  } reading_t;

  reading_t expected_readings[$];

  // The predictor keeps its own copy of the window store and the calibration.
  logic signed [MED_W-1:0] window_store[WINDOW];
  int unsigned next_slot;
  logic [CAL_W-1:0] acid_cal, neutral_cal, base_cal;
  logic [GAIN_W-1:0] gain_q12;

  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;   // chance in percent that the sender inserts a gap
  int stall_pct = 0;       // chance in percent that the receiver stalls

  // Scale one raw reading by the divider gain, round half up, and saturate.
  function automatic logic signed [MED_W-1:0] scaled_sample(logic signed [RAW_W-1:0] raw);
    longint p, q;
    p = longint'(raw) * longint'({1'b0, gain_q12}) + 2048;
    q = p >>> 12;
    if (q < -33554432) q = -33554432;
    if (q > 33554431) q = 33554431;
    return MED_W'(q);
  endfunction

  // Median of the whole store; an even window takes the floored mean of the middle pair.
  function automatic logic signed [MED_W-1:0] store_median();
    longint sorted[WINDOW];
    longint v, sum;
    int j;
    for (int i = 0; i < WINDOW; i++) begin
      v = window_store[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (WINDOW % 2 == 0) begin
      sum = sorted[WINDOW/2-1] + sorted[WINDOW/2];
      return MED_W'(sum >>> 1);
    end
    return MED_W'(sorted[WINDOW/2]);
  endfunction

  // Work out the result of one transaction and advance the predictor state.
  function automatic reading_t predict_reading(logic signed [RAW_W-1:0] raw, logic ok,
                                               logic signed [TEMP_W-1:0] temp);
    reading_t r;
    longint na, aa, ba, da, db, p, qv, ph;
    logic signed [255:0] num, den, quot, rem, term;
    if (ok) begin
      window_store[next_slot] = scaled_sample(raw);
      next_slot = (next_slot + 1) % WINDOW;
    end
    r.median = store_median();
    r.ph = '0;
    r.status = ST_OK;
    na = longint'(neutral_cal) * longint'(gain_q12);
    aa = longint'(acid_cal) * longint'(gain_q12);
    ba = longint'(base_cal) * longint'(gain_q12);
    if (na == aa || na == ba) begin
      r.status = ST_DEGEN;
    end else begin
      da = na - aa;
      db = na - ba;
      p = 2990 * db - 3000 * da;
      qv = longint'(r.median) * (longint'(temp) + 27315) - 64'sd44722500000;
      num = 256'(p) * 256'(qv) * 2048;
      den = 256'(da) * 256'(db) * 29815;
      // Round to nearest with ties away from zero, working on magnitudes.
      if (num < 0) num = -num;
      quot = den;
      if (quot < 0) den = -den;
      quot = num / den;
      rem = num % den;
      if (2 * rem >= den) quot = quot + 1;
      if (quot > (256'sd1 << 40)) quot = 256'sd1 << 40;
      term = ((p < 0) != (qv < 0)) != ((da < 0) != (db < 0)) ? -quot : quot;
      ph = 7000 + longint'(term);
      if (ph > 32767) begin
        ph = 32767;
        r.status = ST_SAT;
      end else if (ph < -32768) begin
        ph = -32768;
        r.status = ST_SAT;
      end
      r.ph = PH_W'(ph);
    end
    return r;
  endfunction

  // Write one calibration register through the APB port: a setup phase, then an access phase.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACID:    acid_cal = value[CAL_W-1:0];
      REG_NEUTRAL: neutral_cal = value[CAL_W-1:0];
      REG_BASE:    base_cal = value[CAL_W-1:0];
      REG_GAIN:    gain_q12 = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid, wait until every expected result has arrived, then let the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_calibration(logic [CAL_W-1:0] a, logic [CAL_W-1:0] n,
                                 logic [CAL_W-1:0] b, logic [GAIN_W-1:0] g);
    wait_drained();
    write_reg(REG_ACID, 32'(a));
    write_reg(REG_NEUTRAL, 32'(n));
    write_reg(REG_BASE, 32'(b));
    write_reg(REG_GAIN, 32'(g));
  endtask

  // Send one transaction; valid stays high across back-to-back items.
  task automatic send_sample(logic signed [RAW_W-1:0] raw, logic ok,
                             logic signed [TEMP_W-1:0] temp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_sample_uv_i <= raw;
    sample_ok_i <= ok;
    temp_centi_c_i <= temp;
    do @(posedge clk_i); while (in_stall_o);
    expected_readings.push_back(predict_reading(raw, ok, temp));
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [RAW_W-1:0] random_raw();
    case ($urandom_range(3))
      0: return RAW_W'($urandom);
      1: return RAW_W'(int'($urandom_range(12288000)) - 6144000);
      default: return RAW_W'(int'($urandom_range(1400000)) - 200000);
    endcase
  endfunction

  function automatic logic signed [TEMP_W-1:0] random_temp();
    if ($urandom_range(4) == 0) return TEMP_W'($urandom);
    return TEMP_W'(int'($urandom_range(20000)) - 5000);
  endfunction

  // Field extremes, skipped storage and a saturating gain.
  task automatic test_directed_extremes();
    send_sample(24'sh7fffff, 1'b1, 15'sd0);
    send_sample(-24'sh800000, 1'b1, 15'sd2500);
    send_sample(24'sd6144000, 1'b1, -15'sd5000);
    send_sample(-24'sd6144000, 1'b1, 15'sd15000);
    send_sample(24'sd0, 1'b0, 15'sh3fff);
    send_sample(-24'sd1, 1'b1, -15'sh4000);
    send_sample(24'sd1, 1'b1, 15'sd2500);
    for (int i = 0; i < 10; i++) send_sample(24'sd750000 + 24'(i * 1000), 1'b1, 15'sd2500);
    send_sample(24'sd123456, 1'b0, 15'sd1000);
    set_calibration(23'd1025130, 23'd755250, 23'd502500, 16'hffff);
    send_sample(24'sh7fffff, 1'b1, 15'sd2500);
    send_sample(-24'sh800000, 1'b1, 15'sd2500);
    send_sample(24'sd2049, 1'b1, 15'sd2500);
  endtask

  // Degenerate calibrations, including a zero gain and equal points, then a zero neutral point.
  task automatic test_degenerate_cal();
    set_calibration(23'd1025130, 23'd755250, 23'd502500, 16'd0);
    send_sample(24'sd500000, 1'b1, 15'sd2500);
    send_sample(-24'sd500000, 1'b1, 15'sd2500);
    set_calibration(23'd755250, 23'd755250, 23'd502500, 16'd4096);
    send_sample(24'sd300000, 1'b1, 15'sd0);
    set_calibration(23'd0, 23'd6144000, 23'd6144000, 16'd4096);
    send_sample(24'sd300000, 1'b1, 15'sd0);
    set_calibration(23'h7fffff, 23'd0, 23'd6144000, 16'd4096);
    send_sample(24'sd700000, 1'b1, 15'sd9000);
    send_sample(-24'sd6000000, 1'b1, -15'sd5000);
  endtask

  // Random samples under one calibration and one idling pattern.
  task automatic test_random_phase(int n, int idle_pct, int stall_p);
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    for (int i = 0; i < n; i++) send_sample(random_raw(), $urandom_range(3) != 0, random_temp());
    idle_input();
  endtask

  task automatic test_random_calibrations();
    logic [CAL_W-1:0] a, n, b;
    for (int k = 0; k < 10; k++) begin
      n = CAL_W'($urandom_range(1000000, 400000));
      a = n + CAL_W'($urandom_range(400000, 1));
      b = n - CAL_W'($urandom_range(350000, 1));
      if (k % 3 == 0) begin
        a = CAL_W'($urandom);
        b = CAL_W'($urandom);
        n = CAL_W'($urandom_range(6144000));
      end
      set_calibration(a, n, b, (k % 4 == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(9000, 3000)));
      test_random_phase(140, (k % 4 == 1) ? 48 : ((k % 4 == 3) ? 6 : 0),
                        (k % 4 == 2) ? 48 : ((k % 4 == 3) ? 6 : 0));
    end
  endtask

  // The result channel: random stalls and an in-order compare against the predictor.
  always @(posedge clk_i) begin
    reading_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result median %0d ph %0d status %0d", $time,
                   median_uv_o, ph_milli_o, status_o);
          errors++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (median_uv_o !== exp_r.median) begin
            $display("%0t: median expected %0d actual %0d", $time, exp_r.median, median_uv_o);
            errors++;
          end
          if (ph_milli_o !== exp_r.ph) begin
            $display("%0t: pH expected %0d actual %0d", $time, exp_r.ph, ph_milli_o);
            errors++;
          end
          if (status_o !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // The watchdog counts cycles in which no transaction moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < WINDOW; i++) window_store[i] = '0;
    next_slot = 0;
    acid_cal = ACID_RST;
    neutral_cal = NEUTRAL_RST;
    base_cal = BASE_RST;
    gain_q12 = GAIN_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_degenerate_cal();
    set_calibration(ACID_RST, NEUTRAL_RST, BASE_RST, GAIN_RST);
    test_random_phase(50, 0, 0);
    // The sender holds off here until the block has handed over every result.
    wait_drained();
    test_random_calibrations();
    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/mwphc_pkg.sv
sv/mwphc_cell.sv
sv/mwphc_chain.sv
sv/mwphc_ph.sv
sv/median_window_ph_calibration.sv
sv/mwphc_checker.sv
test/testbench.sv
